// ----- sv/csd_pkg.sv -----
package csd_pkg;

  localparam int FrameBytes = 8;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  // configuration register indexes
  localparam logic [2:0] REG_BYTE_OFFSET = 3'd0;
  localparam logic [2:0] REG_BYTE_COUNT  = 3'd1;
  localparam logic [2:0] REG_FORMAT      = 3'd2;
  localparam logic [2:0] REG_SCALE       = 3'd3;
  localparam logic [2:0] REG_OFFSET      = 3'd4;
  localparam logic [2:0] REG_MIN         = 3'd5;
  localparam logic [2:0] REG_MAX         = 3'd6;

  // format flag bits
  localparam int FMT_LITTLE = 0;
  localparam int FMT_SIGNED = 1;
  localparam int FMT_FLOAT  = 2;

  // per-word side info that rides along the arithmetic pipe
  typedef struct packed {
    logic        nofit;
    logic        flt;
    logic [31:0] raw;
  } csd_side_t;

  // field layout settings
  typedef struct packed {
    logic [2:0] first_byte;
    logic [2:0] byte_count;
    logic [2:0] format;
  } csd_fmt_t;

  // leading zero count, counted from bit 63
  function automatic logic [5:0] lzc64(input logic [63:0] x);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found) begin
        if (x[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
  endfunction

  // ordered a < b; false when either is NaN, zeros compare equal
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (is_nan(a) || is_nan(b)) r = 1'b0;
    else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) r = 1'b0;
    else if (a[31] != b[31]) r = a[31];
    else if (!a[31]) r = a[30:0] < b[30:0];
    else r = a[30:0] > b[30:0];
    return r;
  endfunction

  // Round to nearest even. m has its leading one at bit 49, e is the biased
  // exponent that bit would carry; e below one gives a subnormal.
  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [9:0] e,
                                           input logic [49:0] m, input logic stk);
    logic signed [10:0] shv;
    logic [5:0]         sh;
    logic [49:0]        den;
    logic               lost;
    logic [7:0]         ef;
    logic               g;
    logic               s;
    logic               inc;
    logic [30:0]        mag;
    logic [31:0]        r;
    shv = 11'sd1 - {e[9], e};
    if (e >= 10'sd1) begin
      den = m;
      ef = e[7:0];
      lost = stk;
    end else begin
      sh = (shv > 11'sd50) ? 6'd50 : shv[5:0];
      den = m >> sh;
      ef = 8'd0;
      lost = stk | (|(m & ~({50{1'b1}} << sh)));
    end
    g = den[25];
    s = (|den[24:0]) | lost;
    inc = g & (s | den[26]);
    mag = {ef, den[48:26]} + {30'd0, inc};
    if (e >= 10'sd255) r = {sgn, 8'hFF, 23'd0};
    else r = {sgn, mag};
    return r;
  endfunction

endpackage

// ----- sv/csd_int2fp.sv -----
module csd_int2fp import csd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] frame_data,
  input  logic [3:0]  frame_length,
  input  csd_fmt_t    fmt,
  output logic        out_valid,
  output logic [31:0] conv,
  output csd_side_t   out_side
);

  // stage 1: gather field, fit check, sign handling
  logic [2:0]  cnt;
  logic [3:0]  len;
  logic [7:0]  b [4];
  logic [31:0] mask;
  logic [31:0] le_raw;
  logic [31:0] be_raw;
  logic [31:0] raw;
  logic [31:0] ext;
  logic        neg;
  logic [3:0]  idx [4];

  always_comb begin
    if (fmt.byte_count == 3'd0) cnt = 3'd1;
    else if (fmt.byte_count > 3'd4) cnt = 3'd4;
    else cnt = fmt.byte_count;
    len = (frame_length > 4'(FrameBytes)) ? 4'(FrameBytes) : frame_length;
    for (int i = 0; i < 4; i++) begin
      idx[i] = {1'b0, fmt.first_byte} + 4'(i);
      b[i] = idx[i][3] ? 8'd0 : frame_data[idx[i][2:0]*8 +: 8];
    end
    unique case (cnt)
      3'd1: mask = 32'h0000_00FF;
      3'd2: mask = 32'h0000_FFFF;
      3'd3: mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    le_raw = {b[3], b[2], b[1], b[0]} & mask;
    be_raw = {b[0], b[1], b[2], b[3]} >> ({3'd4 - cnt, 3'd0});
    raw = fmt.format[FMT_LITTLE] ? le_raw : be_raw;
    ext = (fmt.format[FMT_SIGNED] && ((raw & ~(mask >> 1)) & mask) != 32'd0) ?
          (raw | ~mask) : raw;
    neg = fmt.format[FMT_SIGNED] & ext[31];
  end

  logic        s1_valid;
  logic [31:0] s1_mag;
  logic        s1_neg;
  csd_side_t   s1_side;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
    if (en) begin
      s1_mag <= neg ? (~ext + 32'd1) : ext;
      s1_neg <= neg;
      s1_side.nofit <= ({1'b0, fmt.first_byte} + {1'b0, cnt}) > len;
      s1_side.flt <= fmt.format[FMT_FLOAT];
      s1_side.raw <= raw;
    end
  end

  // stage 2: normalize magnitude
  logic        s2_valid;
  logic [31:0] s2_norm;
  logic [5:0]  s2_lz;
  logic        s2_neg;
  logic        s2_zero;
  csd_side_t   s2_side;
  logic [5:0]  lz;

  assign lz = lzc64({s1_mag, 32'd0});

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
    if (en) begin
      s2_norm <= s1_mag << lz[4:0];
      s2_lz <= lz;
      s2_neg <= s1_neg;
      s2_zero <= (s1_mag == 32'd0);
      s2_side <= s1_side;
    end
  end

  // stage 3: round to single
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s2_valid;
    if (en) begin
      conv <= s2_zero ? 32'd0 :
              fp_round(s2_neg, 10'sd158 - $signed({4'd0, s2_lz}), {s2_norm, 18'd0}, 1'b0);
      out_side <= s2_side;
    end
  end

endmodule

// ----- sv/csd_fmul.sv -----
module csd_fmul import csd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  csd_side_t   in_side,
  output logic        out_valid,
  output logic [31:0] prod,
  output csd_side_t   out_side
);

  // stage 1: specials and mantissa product
  logic [23:0] ma;
  logic [23:0] mb;
  logic [7:0]  eb;
  logic        a_zero;
  logic        b_zero;

  always_comb begin
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  end

  logic              s1_valid;
  logic [47:0]       s1_p;
  logic signed [9:0] s1_e;
  logic              s1_sgn;
  logic              s1_nan;
  logic              s1_inf;
  logic              s1_zero;
  csd_side_t         s1_side;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
    if (en) begin
      s1_p <= ma * mb;
      s1_e <= $signed({2'd0, a[30:23]}) + $signed({2'd0, eb}) - 10'sd126;
      s1_sgn <= a[31] ^ b[31];
      s1_nan <= is_nan(a) || is_nan(b) || ((is_inf(a) && b_zero) || (is_inf(b) && a_zero));
      s1_inf <= is_inf(a) || is_inf(b);
      s1_zero <= a_zero || b_zero;
      s1_side <= in_side;
    end
  end

  // stage 2: normalize
  logic              s2_valid;
  logic [47:0]       s2_p;
  logic signed [9:0] s2_e;
  logic              s2_sgn;
  logic              s2_nan;
  logic              s2_inf;
  logic              s2_zero;
  csd_side_t         s2_side;
  logic [5:0]        lz;

  assign lz = lzc64({s1_p, 16'd0});

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
    if (en) begin
      s2_p <= s1_p << lz;
      s2_e <= s1_e - $signed({4'd0, lz});
      s2_sgn <= s1_sgn;
      s2_nan <= s1_nan;
      s2_inf <= s1_inf;
      s2_zero <= s1_zero;
      s2_side <= s1_side;
    end
  end

  // stage 3: round
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s2_valid;
    if (en) begin
      priority if (s2_nan) prod <= QNAN_BITS;
      else if (s2_inf) prod <= {s2_sgn, 8'hFF, 23'd0};
      else if (s2_zero) prod <= {s2_sgn, 31'd0};
      else prod <= fp_round(s2_sgn, s2_e, {s2_p, 2'd0}, 1'b0);
      out_side <= s2_side;
    end
  end

endmodule

// ----- sv/csd_fadd.sv -----
module csd_fadd import csd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  csd_side_t   in_side,
  output logic        out_valid,
  output logic [31:0] sum,
  output csd_side_t   out_side
);

  // stage 1: specials, swap, align
  logic [31:0] big;
  logic [31:0] lil;
  logic [7:0]  e_big;
  logic [7:0]  e_lil;
  logic [7:0]  d;
  logic [5:0]  dsat;
  logic [49:0] mb_full;
  logic [49:0] mb_sh;
  logic        mb_lost;

  always_comb begin
    if (b[30:0] > a[30:0]) begin
      big = b;
      lil = a;
    end else begin
      big = a;
      lil = b;
    end
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_lil = (lil[30:23] == 8'd0) ? 8'd1 : lil[30:23];
    d = e_big - e_lil;
    dsat = (d > 8'd50) ? 6'd50 : d[5:0];
    mb_full = {(lil[30:23] != 8'd0), lil[22:0], 26'd0};
    mb_sh = mb_full >> dsat;
    mb_lost = |(mb_full & ~({50{1'b1}} << dsat));
  end

  logic        s1_valid;
  logic [49:0] s1_ma;
  logic [49:0] s1_mb;
  logic        s1_sub;
  logic        s1_sgn;
  logic        s1_zsgn;
  logic [7:0]  s1_e;
  logic        s1_nan;
  logic        s1_inf;
  logic        s1_isgn;
  csd_side_t   s1_side;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
    if (en) begin
      s1_ma <= {(big[30:23] != 8'd0), big[22:0], 26'd0};
      s1_mb <= {mb_sh[49:1], mb_sh[0] | mb_lost};
      s1_sub <= a[31] ^ b[31];
      s1_sgn <= big[31];
      s1_zsgn <= a[31] & b[31];
      s1_e <= e_big;
      s1_nan <= is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]));
      s1_inf <= is_inf(a) || is_inf(b);
      s1_isgn <= is_inf(a) ? a[31] : b[31];
      s1_side <= in_side;
    end
  end

  // stage 2: add or subtract magnitudes
  logic        s2_valid;
  logic [50:0] s2_s;
  logic        s2_sgn;
  logic        s2_zsgn;
  logic [7:0]  s2_e;
  logic        s2_nan;
  logic        s2_inf;
  logic        s2_isgn;
  csd_side_t   s2_side;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
    if (en) begin
      s2_s <= s1_sub ? ({1'b0, s1_ma} - {1'b0, s1_mb}) : ({1'b0, s1_ma} + {1'b0, s1_mb});
      s2_sgn <= s1_sgn;
      s2_zsgn <= s1_zsgn;
      s2_e <= s1_e;
      s2_nan <= s1_nan;
      s2_inf <= s1_inf;
      s2_isgn <= s1_isgn;
      s2_side <= s1_side;
    end
  end

  // stage 3: normalize
  logic              s3_valid;
  logic [50:0]       s3_s;
  logic signed [9:0] s3_e;
  logic              s3_zero;
  logic              s3_sgn;
  logic              s3_zsgn;
  logic              s3_nan;
  logic              s3_inf;
  logic              s3_isgn;
  csd_side_t         s3_side;
  logic [5:0]        lz;

  assign lz = lzc64({s2_s, 13'd0});

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
    if (en) begin
      s3_s <= s2_s << lz;
      s3_e <= $signed({2'd0, s2_e}) + 10'sd1 - $signed({4'd0, lz});
      s3_zero <= (s2_s == 51'd0);
      s3_sgn <= s2_sgn;
      s3_zsgn <= s2_zsgn;
      s3_nan <= s2_nan;
      s3_inf <= s2_inf;
      s3_isgn <= s2_isgn;
      s3_side <= s2_side;
    end
  end

  // stage 4: round; any NaN leaves as the quiet NaN
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s3_valid;
    if (en) begin
      priority if (s3_nan) sum <= QNAN_BITS;
      else if (s3_inf) sum <= {s3_isgn, 8'hFF, 23'd0};
      else if (s3_zero) sum <= {s3_zsgn, 31'd0};
      else sum <= fp_round(s3_sgn, s3_e, s3_s[50:1], s3_s[0]);
      out_side <= s3_side;
    end
  end

endmodule

// ----- sv/csd_clamp.sv -----
module csd_clamp import csd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] sum,
  input  csd_side_t   in_side,
  input  logic [31:0] min_bits,
  input  logic [31:0] max_bits,
  output logic        out_valid,
  output logic [31:0] value_bits,
  output logic        does_not_fit,
  output logic        out_flt
);

  logic [31:0] v;
  logic [31:0] v_lo;
  logic [31:0] res;

  // min first, then max against the possibly replaced value
  always_comb begin
    v = in_side.flt ? in_side.raw : sum;
    v_lo = fp_lt(v, min_bits) ? min_bits : v;
    res = fp_lt(max_bits, v_lo) ? max_bits : v_lo;
    if (in_side.nofit) res = QNAN_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
    if (en) begin
      value_bits <= res;
      does_not_fit <= in_side.nofit;
      out_flt <= in_side.flt;
    end
  end

endmodule

// ----- sv/can_signal_decoder.sv -----
// CAN signal decoder.
// Input stream s_*: one word per frame, s_tdata = frame_data[63:0],
// frame_length[67:64], zero padded to 72 bits. Output stream m_*: one word
// per frame, m_tdata = value_bits (IEEE single), m_tuser = does_not_fit.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 offset,
// 1 byte count, 2 format, 3 scale, 4 offset, 5 min, 6 max); write only
// while no frame is in flight.
// Pipeline: 11 register stages (gather, int-to-float normalize and round,
// multiply, normalize, round, align, add, normalize, round, clamp). The
// accepting edge loads the first stage, and the clamp stage drives m_tvalid.
// Throughput is one frame per cycle unless m_tready stalls the pipe; every
// stage is fully pipelined.
// When m_tready is low with a result waiting, the whole pipe holds and
// s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits, holds s_tready low and loads the register
// defaults (offset 0, count 1, big endian unsigned, scale 1.0, offset 0.0,
// min -inf, max +inf).
module can_signal_decoder import csd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // frame_data[63:0], frame_length[67:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value_bits[31:0]
  output logic [0:0]  m_tuser,   // does_not_fit[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  csd_fmt_t    fmt;
  logic [31:0] scale_bits;
  logic [31:0] offset_bits;
  logic [31:0] min_bits;
  logic [31:0] max_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt.first_byte <= 3'd0;
      fmt.byte_count <= 3'd1;
      fmt.format <= 3'd0;
      scale_bits <= 32'h3F80_0000;
      offset_bits <= 32'd0;
      min_bits <= 32'hFF80_0000;
      max_bits <= 32'h7F80_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYTE_OFFSET: fmt.first_byte <= cfg_data[2:0];
        REG_BYTE_COUNT:  fmt.byte_count <= cfg_data[2:0];
        REG_FORMAT:      fmt.format <= cfg_data[2:0];
        REG_SCALE:       scale_bits <= cfg_data;
        REG_OFFSET:      offset_bits <= cfg_data;
        REG_MIN:         min_bits <= cfg_data;
        REG_MAX:         max_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves whenever the output slot frees up
  logic en;
  assign en = ~m_tvalid | m_tready;
  assign s_tready = en & ~rst;

  logic        cv_valid;
  logic [31:0] conv;
  csd_side_t   cv_side;
  logic        ml_valid;
  logic [31:0] prod;
  csd_side_t   ml_side;
  logic        ad_valid;
  logic [31:0] sum;
  csd_side_t   ad_side;
  logic        out_flt;

  csd_int2fp u_int2fp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .frame_data(s_tdata[63:0]),
    .frame_length(s_tdata[67:64]),
    .fmt(fmt),
    .out_valid(cv_valid), .conv(conv), .out_side(cv_side)
  );

  csd_fmul u_fmul (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cv_valid), .a(conv), .b(scale_bits), .in_side(cv_side),
    .out_valid(ml_valid), .prod(prod), .out_side(ml_side)
  );

  csd_fadd u_fadd (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(ml_valid), .a(prod), .b(offset_bits), .in_side(ml_side),
    .out_valid(ad_valid), .sum(sum), .out_side(ad_side)
  );

  csd_clamp u_clamp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(ad_valid), .sum(sum), .in_side(ad_side),
    .min_bits(min_bits), .max_bits(max_bits),
    .out_valid(m_tvalid), .value_bits(m_tdata), .does_not_fit(m_tuser[0]),
    .out_flt(out_flt)
  );

  // a frame that does not fit always reports the quiet NaN
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == QNAN_BITS)
    else $error("does_not_fit without quiet NaN");

  // arithmetic results never carry a NaN other than the quiet one
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_flt && is_nan(m_tdata) |-> m_tdata == QNAN_BITS)
    else $error("non-canonical NaN from arithmetic path");

  // reset empties the pipe
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import csd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 30;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // frame_data[63:0], frame_length[67:64]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // value_bits[31:0]
  logic [0:0]  m_tuser;   // does_not_fit[0]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  typedef struct {
    logic [31:0] value;
    logic        nofit;
  } decoded_t;

  // one directed step: a register write or a frame, optionally with a typed answer
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] val;
    logic [63:0] data;
    logic [3:0]  len;
    bit          pinned;
    logic [31:0] want_value;
    logic        want_nofit;
  } step_t;

  // register mirror
  logic [2:0]  fld_offset;
  logic [2:0]  fld_count;
  logic [2:0]  fld_format;
  logic [31:0] scale_f;
  logic [31:0] offset_f;
  logic [31:0] min_f;
  logic [31:0] max_f;

  decoded_t    pending_q[$];
  step_t       steps[$];
  bit          cur_pinned;
  decoded_t    cur_answer;
  bit          quiet;
  bit          long_hold_req;
  int          rx_gap;
  int          errors;
  int          cycles;
  int          frames_sent;
  int          words_checked;
  int          nofit_seen;
  int          cfg_writes;

  can_signal_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------- single precision arithmetic ----------------

  function automatic bit f_nan(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != 23'd0;
  endfunction

  function automatic bit f_inf(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] == 23'd0;
  endfunction

  function automatic bit f_zero(input logic [31:0] f);
    return f[30:0] == 31'd0;
  endfunction

  // value = sig * 2^ex, rounded to nearest even into a single
  function automatic logic [31:0] pack_single(input logic sgn, input logic [319:0] sig,
                                              input int ex);
    int           p;
    int           sh;
    int           e;
    logic [319:0] kept;
    logic         g;
    logic         st;
    if (sig == '0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 320; i++) if (sig[i]) p = i;
    sh = p - 23;
    if (-149 - ex > sh) sh = -149 - ex;
    if (sh > 0) begin
      kept = sig >> sh;
      g = sig[sh-1];
      st = |(sig & ((320'd1 << (sh - 1)) - 320'd1));
      if (g && (st || kept[0])) kept = kept + 320'd1;
    end else begin
      kept = sig << (-sh);
    end
    if (kept[24]) begin
      kept = kept >> 1;
      sh++;
    end
    e = ex + sh + 150;
    if (!kept[23]) return {sgn, 8'd0, kept[22:0]};
    if (e >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, e[7:0], kept[22:0]};
  endfunction

  function automatic void unpack_single(input logic [31:0] f, output logic [319:0] sig,
                                        output int ex);
    sig = '0;
    if (f[30:23] == 8'd0) begin
      sig[22:0] = f[22:0];
      ex = -149;
    end else begin
      sig[23:0] = {1'b1, f[22:0]};
      ex = int'(f[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
    logic         s;
    logic [319:0] sa;
    logic [319:0] sb;
    int           ea;
    int           eb;
    s = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return QNAN_BITS;
    if (f_inf(a) || f_inf(b)) begin
      if (f_zero(a) || f_zero(b)) return QNAN_BITS;
      return {s, 8'hFF, 23'd0};
    end
    if (f_zero(a) || f_zero(b)) return {s, 31'd0};
    unpack_single(a, sa, ea);
    unpack_single(b, sb, eb);
    return pack_single(s, sa * sb, ea + eb);
  endfunction

  function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
    logic [319:0] ma;
    logic [319:0] mb;
    int           ea;
    int           eb;
    int           emn;
    if (f_nan(a) || f_nan(b)) return QNAN_BITS;
    if (f_inf(a) && f_inf(b) && a[31] != b[31]) return QNAN_BITS;
    if (f_inf(a)) return a;
    if (f_inf(b)) return b;
    if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
    unpack_single(a, ma, ea);
    unpack_single(b, mb, eb);
    emn = (ea < eb) ? ea : eb;
    ma = ma << (ea - emn);
    mb = mb << (eb - emn);
    if (a[31] == b[31]) return pack_single(a[31], ma + mb, emn);
    if (ma > mb) return pack_single(a[31], ma - mb, emn);
    if (mb > ma) return pack_single(b[31], mb - ma, emn);
    return 32'd0;
  endfunction

  // ordered less-than; NaN compares false, signed zeros are equal
  function automatic bit f_less(input logic [31:0] a, input logic [31:0] b);
    longint ka;
    longint kb;
    if (f_nan(a) || f_nan(b)) return 1'b0;
    ka = a[31] ? -longint'(a[30:0]) : longint'(a[30:0]);
    kb = b[31] ? -longint'(b[30:0]) : longint'(b[30:0]);
    return ka < kb;
  endfunction

  // ---------------- signal decode prediction ----------------

  function automatic decoded_t decode_signal(input logic [63:0] data, input logic [3:0] len_in);
    decoded_t    r;
    int          cnt;
    int          len;
    int          idx;
    logic [31:0] raw;
    logic [31:0] mag;
    logic [31:0] val;
    logic [7:0]  b;
    bit          neg;
    cnt = fld_count;
    if (cnt == 0) cnt = 1;
    if (cnt > 4) cnt = 4;
    len = (len_in > FrameBytes) ? FrameBytes : len_in;
    r.nofit = 1'b0;
    if (fld_offset + cnt > len) begin
      r.value = QNAN_BITS;
      r.nofit = 1'b1;
      return r;
    end
    raw = '0;
    for (int i = 0; i < cnt; i++) begin
      idx = fld_format[FMT_LITTLE] ? fld_offset + cnt - 1 - i : fld_offset + i;
      b = (idx < 8) ? data[idx*8 +: 8] : 8'd0;
      raw = {raw[23:0], b};
    end
    if (fld_format[FMT_FLOAT]) begin
      val = raw;
    end else begin
      if (fld_format[FMT_SIGNED] && cnt < 4 && raw[cnt*8-1]) raw = raw | ('1 << (cnt * 8));
      neg = fld_format[FMT_SIGNED] && raw[31];
      mag = neg ? -raw : raw;
      val = pack_single(neg, {288'd0, mag}, 0);
      val = f_add(f_mul(val, scale_f), offset_f);
      if (f_nan(val)) val = QNAN_BITS;
    end
    // clamp low, then high
    if (f_less(val, min_f)) val = min_f;
    if (f_less(max_f, val)) val = max_f;
    r.value = val;
    return r;
  endfunction

  // ---------------- cycle counter and timeout ----------------

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_q.size());
      $display("can_signal_decoder verification failed");
      $finish;
    end
  end

  // ---------------- input and output monitors ----------------

  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (!rst && s_tvalid && s_tready) begin
      pending_q.push_back(cur_pinned ? cur_answer : decode_signal(s_tdata[63:0], s_tdata[67:64]));
    end
    if (!rst && m_tvalid && m_tready) begin
      got.value = m_tdata;
      got.nofit = m_tuser[0];
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected: value %h nofit %b", got.value, got.nofit);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.value !== want.value) begin
          $error("value_bits: expected %h, got %h", want.value, got.value);
          errors++;
        end
        if (got.nofit !== want.nofit) begin
          $error("does_not_fit: expected %b, got %b", want.nofit, got.nofit);
          errors++;
        end
        words_checked++;
        if (got.nofit) nofit_seen++;
      end
    end
  end

  // ---------------- receiver back-pressure ----------------

  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_gap = 300;
    end
    if (rx_gap > 0) begin
      rx_gap--;
      m_tready = 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(1, 15) - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  // ---------------- drivers ----------------

  task automatic wait_idle();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_BYTE_OFFSET: fld_offset = val[2:0];
      REG_BYTE_COUNT:  fld_count = val[2:0];
      REG_FORMAT:      fld_format = val[2:0];
      REG_SCALE:       scale_f = val;
      REG_OFFSET:      offset_f = val;
      REG_MIN:         min_f = val;
      REG_MAX:         max_f = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_frame(input logic [63:0] data, input logic [3:0] len, input bit pinned,
                            input decoded_t answer);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {4'd0, len, data};
    cur_pinned = pinned;
    cur_answer = answer;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frames_sent++;
    @(negedge clk);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [31:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    steps.push_back(s);
  endtask

  task automatic add_frame(input logic [63:0] data, input logic [3:0] len, input bit pinned,
                           input logic [31:0] wv, input logic wn);
    step_t s;
    s = '{default: '0};
    s.data = data;
    s.len = len;
    s.pinned = pinned;
    s.want_value = wv;
    s.want_nofit = wn;
    steps.push_back(s);
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 9))
      0: return 32'h3F80_0000;
      1: return $urandom;
      2: return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
      3: return {1'($urandom), 8'hFF, 23'd0};
      4: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
      5: return {1'($urandom), 31'd0};
      6: return {1'($urandom), 31'h7F7F_FFFF};
      default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_limit(input bit low);
    case ($urandom_range(0, 5))
      0, 1, 2: return low ? 32'hFF80_0000 : 32'h7F80_0000;
      3: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
      default: return {1'($urandom), 8'($urandom_range(120, 160)), 23'($urandom)};
    endcase
  endfunction

  // ---------------- stimulus ----------------

  initial begin
    decoded_t    ans;
    logic [63:0] data;
    logic [3:0]  len;
    int          n_phases;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_BYTE_OFFSET;
    cfg_data = '0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    rx_gap = 0;
    errors = 0;
    cycles = 0;
    frames_sent = 0;
    words_checked = 0;
    nofit_seen = 0;
    cfg_writes = 0;
    cur_pinned = 1'b0;
    cur_answer = '{default: '0};
    fld_offset = 3'd0;
    fld_count = 3'd1;
    fld_format = 3'd0;
    scale_f = 32'h3F80_0000;
    offset_f = 32'h0000_0000;
    min_f = 32'hFF80_0000;
    max_f = 32'h7F80_0000;
    n_phases = 12;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    add_frame(64'hAB, 4'd1, 1, 32'h432B_0000, 1'b0);             // defaults: 171.0
    add_frame(64'hAB, 4'd0, 1, QNAN_BITS, 1'b1);                 // empty frame
    add_frame(64'hFFFF_FFFF_FFFF_FF80, 4'd15, 0, '0, 1'b0);      // length saturates
    add_cfg(REG_BYTE_COUNT, 32'd4);
    add_frame(64'hFFFF_FFFF, 4'd4, 1, 32'h4F80_0000, 1'b0);      // unsigned stays positive
    add_cfg(REG_FORMAT, 32'd2);
    add_frame(64'hFFFF_FFFF, 4'd4, 1, 32'hBF80_0000, 1'b0);      // signed -1
    add_cfg(REG_FORMAT, 32'd3);
    add_frame(64'h8000_0000, 4'd8, 1, 32'hCF00_0000, 1'b0);      // little endian -2^31
    add_cfg(REG_BYTE_OFFSET, 32'd4);
    add_frame(64'h1234_5678_9ABC_DEF0, 4'd7, 1, QNAN_BITS, 1'b1); // one byte short
    add_frame(64'h8123_4567_89AB_CDEF, 4'd8, 0, '0, 1'b0);
    add_cfg(REG_BYTE_OFFSET, 32'd7);
    add_cfg(REG_BYTE_COUNT, 32'd0);                              // zero count acts as one
    add_frame(64'hFF00_0000_0000_0000, 4'd8, 0, '0, 1'b0);
    add_cfg(REG_BYTE_COUNT, 32'd7);                              // count saturates to four
    add_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1, QNAN_BITS, 1'b1);
    add_cfg(REG_BYTE_OFFSET, 32'd0);
    add_cfg(REG_FORMAT, 32'd4);
    add_frame(64'h0100_A07F, 4'd8, 1, 32'h7FA0_0001, 1'b0);      // raw NaN passes unchanged
    add_cfg(REG_BYTE_COUNT, 32'd2);
    add_cfg(REG_FORMAT, 32'd5);
    add_frame(64'h0000_0000_0000_C03F, 4'd2, 0, '0, 1'b0);       // short raw float
    add_cfg(REG_FORMAT, 32'd0);
    add_cfg(REG_BYTE_COUNT, 32'd1);
    add_cfg(REG_SCALE, 32'h7F80_0000);
    add_frame(64'h0, 4'd1, 1, QNAN_BITS, 1'b0);                  // 0 * inf
    add_frame(64'h1, 4'd1, 1, 32'h7F80_0000, 1'b0);
    add_cfg(REG_SCALE, 32'h3F80_0000);
    add_cfg(REG_MIN, 32'h4000_0000);
    add_frame(64'h1, 4'd1, 1, 32'h4000_0000, 1'b0);              // clamped to min
    add_cfg(REG_MAX, 32'h4040_0000);
    add_frame(64'hC8, 4'd1, 1, 32'h4040_0000, 1'b0);             // clamped to max
    add_cfg(REG_MIN, 32'h7FC0_0001);
    add_cfg(REG_MAX, 32'hFFC0_0001);
    add_frame(64'hC8, 4'd1, 0, '0, 1'b0);                        // NaN limits ignored
    add_cfg(REG_SCALE, 32'h0000_0001);
    add_cfg(REG_OFFSET, 32'h8000_0000);
    add_frame(64'h7F, 4'd1, 0, '0, 1'b0);                        // subnormal product
    add_cfg(REG_SCALE, 32'h7F7F_FFFF);
    add_frame(64'hFF, 4'd1, 0, '0, 1'b0);                        // overflow to inf

    @(negedge clk);
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        s_tvalid = 1'b0;
        write_reg(steps[i].idx, steps[i].val);
      end else begin
        ans.value = steps[i].want_value;
        ans.nofit = steps[i].want_nofit;
        send_frame(steps[i].data, steps[i].len, steps[i].pinned, ans);
      end
    end

    // random phases, each under a fresh register setting
    ans = '{default: '0};
    for (int ph = 0; ph < n_phases; ph++) begin
      s_tvalid = 1'b0;
      write_reg(REG_BYTE_OFFSET, 32'($urandom_range(0, 7)));
      write_reg(REG_BYTE_COUNT, 32'($urandom_range(0, 7)));
      write_reg(REG_FORMAT, 32'($urandom_range(0, 7)));
      write_reg(REG_SCALE, pick_float());
      write_reg(REG_OFFSET, pick_float());
      write_reg(REG_MIN, pick_limit(1'b1));
      write_reg(REG_MAX, pick_limit(1'b0));
      // keep the field inside a full frame most of the time
      if ($urandom_range(0, 3) != 0 && fld_offset > 4) write_reg(REG_BYTE_OFFSET, 32'd4);
      if (ph == 3) long_hold_req = 1'b1;
      if (ph == n_phases - 1) quiet = 1'b1;
      for (int k = 0; k < 125; k++) begin
        data = {$urandom, $urandom};
        len = ($urandom_range(0, 9) < 7) ? 4'd8 : 4'($urandom_range(0, 15));
        send_frame(data, len, 1'b0, ans);
      end
    end
    s_tvalid = 1'b0;

    // drain
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    $display("%0d frames sent, %0d result words checked (%0d out of range), %0d register writes",
             frames_sent, words_checked, nofit_seen, cfg_writes);
    $display("covered endianness, signedness, raw float, clamping and float specials");
    if (errors == 0) begin
      $display("can_signal_decoder verification clean");
    end else begin
      $display("can_signal_decoder verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/csd_pkg.sv
sv/csd_int2fp.sv
sv/csd_fmul.sv
sv/csd_fadd.sv
sv/csd_clamp.sv
sv/can_signal_decoder.sv
tb/tb.sv
